// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lutt_pkg.sv =====
package lutt_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned LUM_W      = 24;
    localparam int unsigned SCALE_W    = 20;
    localparam int unsigned TINT_W     = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PROD_W     = SCALE_W + LUM_W;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;
    localparam int unsigned DIV_STEPS  = 21;
    localparam int unsigned DIV_CNT_W  = 5;
    localparam int unsigned NUM_W      = 40;
    localparam int unsigned NCH        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT   = 2'd3;

    localparam logic [1:0] BLEND_REPLACE = 2'd0;
    localparam logic [1:0] BLEND_ADD     = 2'd1;
    localparam logic [1:0] BLEND_AVG     = 2'd2;

    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    localparam logic [LUM_W-1:0]   LUMA_FULL   = 24'hFF0000;
    localparam logic [SCALE_W-1:0] SCALE_UNITY = 20'h10000;
    localparam logic [SCALE_W-1:0] SCALE_MAX   = 20'hFFFFF;
    localparam logic [TINT_W-1:0]  TINT_RESET  = 24'hFFFFFF;
    localparam logic [PIX_W-1:0]   PIX_MAX     = 8'hFF;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic             in_last;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             out_last;
    } t_rsp;

    typedef struct packed {
        logic       enable;
        logic       invert_luma;
        logic [1:0] blend_select;
    } t_cfg;

    typedef struct packed {
        t_req             pix;
        logic [LUM_W-1:0] lum;
    } t_work;

    typedef struct packed {
        logic [SCALE_W-1:0] red;
        logic [SCALE_W-1:0] green;
        logic [SCALE_W-1:0] blue;
    } t_scales;

    function automatic logic [LUM_W-1:0] luma(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
        logic [LUM_W+1:0] s;
        s = (26'(LUMA_WR) * 26'(r)) + (26'(LUMA_WG) * 26'(g)) + (26'(LUMA_WB) * 26'(b));
        return s[LUM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/luminance_tone_tint.sv =====
// A request passes the front register, the queue, then back registers A and B to o_rsp.
// One request per cycle while o_full is low; a four-entry queue splits front and back stalls.
// A tint_color write starts a 21-step restoring divide for the three scales; o_full
// stays high from that write until the new scales are loaded.
// Reset (synchronous, i_rst_n low): queues empty, enable=1, invert=0, replace blend,
// white tint with unity scales.
`include "assert_macros.svh"

module luminance_tone_tint (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  lutt_pkg::t_req                  i_req,
    output logic                            o_empty,
    input  logic                            i_pop,
    output lutt_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [lutt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lutt_pkg::TINT_W-1:0]     i_cfg_data
);

    logic                            r_enable;
    logic                            r_invert_luma;
    logic [1:0]                      r_blend_select;
    logic [lutt_pkg::TINT_W-1:0]     r_tint_color;

    lutt_pkg::t_cfg                  cfg;
    lutt_pkg::t_scales               scales;
    lutt_pkg::t_work                 front_work;
    lutt_pkg::t_work                 q_work;
    logic                            tint_wr;
    logic                            tint_black;
    logic                            scale_busy;
    logic                            front_ready;
    logic                            front_valid;
    logic                            q_full;
    logic                            q_valid;
    logic                            q_pop;
    logic                            push_ok;

    assign tint_wr    = i_cfg_we && (i_cfg_idx == lutt_pkg::CFG_TINT);
    assign tint_black = (r_tint_color == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b1;
            r_invert_luma  <= 1'b0;
            r_blend_select <= lutt_pkg::BLEND_REPLACE;
            r_tint_color   <= lutt_pkg::TINT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lutt_pkg::CFG_ENABLE: r_enable       <= i_cfg_data[0];
                lutt_pkg::CFG_INVERT: r_invert_luma  <= i_cfg_data[0];
                lutt_pkg::CFG_BLEND:  r_blend_select <= i_cfg_data[1:0];
                lutt_pkg::CFG_TINT:   r_tint_color   <= i_cfg_data;
                default:              r_enable       <= r_enable;
            endcase
        end
    end

    assign cfg.enable       = r_enable;
    assign cfg.invert_luma  = r_invert_luma;
    assign cfg.blend_select = r_blend_select;

    assign o_full  = !front_ready || scale_busy || tint_wr;
    assign push_ok = i_push && !scale_busy && !tint_wr;

    lutt_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (tint_wr),
        .i_tint   (r_tint_color),
        .o_busy   (scale_busy),
        .o_scales (scales)
    );

    lutt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_ok),
        .i_req     (i_req),
        .i_cfg     (cfg),
        .i_q_ready (!q_full),
        .o_ready   (front_ready),
        .o_valid   (front_valid),
        .o_work    (front_work)
    );

    lutt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    lutt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_work  (q_work),
        .o_q_pop   (q_pop),
        .i_cfg     (cfg),
        .i_scales  (scales),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_rsp     (o_rsp)
    );

    `ASSERT_NEXT(a_tint_starts_divide, tint_wr, scale_busy, "tint write did not start divide")
    `ASSERT_SAME(a_busy_blocks_req, scale_busy, o_full, "request taken during scale update")
    `ASSERT_SAME(a_black_tint_zero, $fell(scale_busy) && tint_black, (scales == '0), "black tint")

endmodule

// ===== hw/rtl/lutt_scale.sv =====
module lutt_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lutt_pkg::TINT_W-1:0]  i_tint,
    output logic                         o_busy,
    output lutt_pkg::t_scales            o_scales
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LUMA = 4'b0010,
        S_LOAD = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state                              r_state;
    logic [lutt_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [lutt_pkg::LUM_W-1:0]          r_lt;
    logic [lutt_pkg::LUM_W-1:0]          r_rem   [lutt_pkg::NCH];
    logic [lutt_pkg::DIV_STEPS-1:0]      r_num   [lutt_pkg::NCH];
    logic [lutt_pkg::DIV_STEPS-1:0]      r_quo   [lutt_pkg::NCH];
    logic                                r_ovf   [lutt_pkg::NCH];
    logic [lutt_pkg::SCALE_W-1:0]        r_scale [lutt_pkg::NCH];

    logic [lutt_pkg::PIX_W-1:0]          chan    [lutt_pkg::NCH];
    logic [lutt_pkg::NUM_W-1:0]          numer   [lutt_pkg::NCH];
    logic [lutt_pkg::LUM_W:0]            rem_sh  [lutt_pkg::NCH];
    logic                                ge      [lutt_pkg::NCH];
    logic [lutt_pkg::DIV_STEPS-1:0]      quo_fin [lutt_pkg::NCH];
    logic [lutt_pkg::SCALE_W-1:0]        n_scale [lutt_pkg::NCH];
    logic                                last_step;

    assign chan[0] = i_tint[23:16];
    assign chan[1] = i_tint[15:8];
    assign chan[2] = i_tint[7:0];

    assign last_step = (r_cnt == lutt_pkg::DIV_CNT_W'(lutt_pkg::DIV_STEPS - 1));

    always_comb begin
        for (int k = 0; k < lutt_pkg::NCH; k++) begin
            numer[k]   = {chan[k], 32'd0} + lutt_pkg::NUM_W'(r_lt[lutt_pkg::LUM_W-1:1]);
            rem_sh[k]  = {r_rem[k], r_num[k][lutt_pkg::DIV_STEPS-1]};
            ge[k]      = (rem_sh[k] >= (lutt_pkg::LUM_W + 1)'(r_lt));
            quo_fin[k] = {r_quo[k][lutt_pkg::DIV_STEPS-2:0], ge[k]};
            if (r_lt == '0) begin
                n_scale[k] = '0;
            end else if (r_ovf[k] || quo_fin[k][lutt_pkg::DIV_STEPS-1]) begin
                n_scale[k] = lutt_pkg::SCALE_MAX;
            end else begin
                n_scale[k] = quo_fin[k][lutt_pkg::SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            for (int k = 0; k < lutt_pkg::NCH; k++) begin
                r_scale[k] <= lutt_pkg::SCALE_UNITY;
            end
        end else if (i_start) begin
            r_state <= S_LUMA;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                S_LUMA: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last_step) begin
                        for (int k = 0; k < lutt_pkg::NCH; k++) begin
                            r_scale[k] <= n_scale[k];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LUMA) begin
            r_lt <= lutt_pkg::luma(chan[0], chan[1], chan[2]);
        end
        for (int k = 0; k < lutt_pkg::NCH; k++) begin
            if (r_state == S_LOAD) begin
                r_rem[k] <= lutt_pkg::LUM_W'(numer[k][lutt_pkg::NUM_W-1:lutt_pkg::DIV_STEPS]);
                r_ovf[k] <= (lutt_pkg::LUM_W'(numer[k][lutt_pkg::NUM_W-1:lutt_pkg::DIV_STEPS])
                             >= r_lt);
                r_num[k] <= numer[k][lutt_pkg::DIV_STEPS-1:0];
                r_quo[k] <= '0;
            end else if (r_state == S_DIV) begin
                r_rem[k] <= ge[k] ? lutt_pkg::LUM_W'(rem_sh[k] - (lutt_pkg::LUM_W + 1)'(r_lt))
                                  : rem_sh[k][lutt_pkg::LUM_W-1:0];
                r_num[k] <= {r_num[k][lutt_pkg::DIV_STEPS-2:0], 1'b0};
                r_quo[k] <= quo_fin[k];
            end
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_scales.red   = r_scale[0];
    assign o_scales.green = r_scale[1];
    assign o_scales.blue  = r_scale[2];

endmodule

// ===== hw/rtl/lutt_front.sv =====
module lutt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lutt_pkg::t_req    i_req,
    input  lutt_pkg::t_cfg    i_cfg,
    input  logic              i_q_ready,
    output logic              o_ready,
    output logic              o_valid,
    output lutt_pkg::t_work   o_work
);

    logic                          r_valid;
    lutt_pkg::t_work               r_work;
    lutt_pkg::t_work               n_work;
    logic [lutt_pkg::LUM_W-1:0]    lum;

    assign lum = lutt_pkg::luma(i_req.in_red, i_req.in_green, i_req.in_blue);

    always_comb begin
        n_work.pix = i_req;
        n_work.lum = i_cfg.invert_luma ? (lutt_pkg::LUMA_FULL - lum) : lum;
    end

    assign o_ready = !r_valid || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ===== hw/rtl/lutt_fifo.sv =====
module lutt_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lutt_pkg::t_work   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output lutt_pkg::t_work   o_data
);

    lutt_pkg::t_work                    r_mem [lutt_pkg::FIFO_DEPTH];
    logic [lutt_pkg::FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [lutt_pkg::FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [lutt_pkg::FIFO_CNT_W-1:0]    r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_full  = (r_count == lutt_pkg::FIFO_CNT_W'(lutt_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

endmodule

// ===== hw/rtl/lutt_back.sv =====
module lutt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lutt_pkg::t_work    i_q_work,
    output logic               o_q_pop,
    input  lutt_pkg::t_cfg     i_cfg,
    input  lutt_pkg::t_scales  i_scales,
    output logic               o_empty,
    input  logic               i_pop,
    output lutt_pkg::t_rsp     o_rsp
);

    logic                              r_a_valid;
    lutt_pkg::t_req                    r_a_pix;
    logic [lutt_pkg::PROD_W-1:0]       r_a_prod [lutt_pkg::NCH];
    logic                              r_b_valid;
    lutt_pkg::t_rsp                    r_b_rsp;

    logic                              a_ready;
    logic                              b_ready;
    logic [lutt_pkg::SCALE_W-1:0]      scale  [lutt_pkg::NCH];
    logic [lutt_pkg::PIX_W-1:0]        px     [lutt_pkg::NCH];
    logic [lutt_pkg::PROD_W:0]         rsum   [lutt_pkg::NCH];
    logic [12:0]                       tfull  [lutt_pkg::NCH];
    logic [lutt_pkg::PIX_W-1:0]        tone   [lutt_pkg::NCH];
    logic [lutt_pkg::PIX_W:0]          psum   [lutt_pkg::NCH];
    logic [lutt_pkg::PIX_W-1:0]        res    [lutt_pkg::NCH];
    lutt_pkg::t_rsp                    n_rsp;

    assign scale[0] = i_scales.red;
    assign scale[1] = i_scales.green;
    assign scale[2] = i_scales.blue;
    assign px[0]    = r_a_pix.in_red;
    assign px[1]    = r_a_pix.in_green;
    assign px[2]    = r_a_pix.in_blue;

    assign b_ready = !r_b_valid || i_pop;
    assign a_ready = !r_a_valid || b_ready;
    assign o_q_pop = i_q_valid && a_ready;

    always_comb begin
        for (int k = 0; k < lutt_pkg::NCH; k++) begin
            rsum[k]  = (lutt_pkg::PROD_W + 1)'(r_a_prod[k]) + (lutt_pkg::PROD_W + 1)'(33'h080000000);
            tfull[k] = rsum[k][lutt_pkg::PROD_W:32];
            tone[k]  = (tfull[k] > 13'(lutt_pkg::PIX_MAX)) ? lutt_pkg::PIX_MAX
                                                          : tfull[k][lutt_pkg::PIX_W-1:0];
            psum[k]  = (lutt_pkg::PIX_W + 1)'(px[k]) + (lutt_pkg::PIX_W + 1)'(tone[k]);
            if (!i_cfg.enable) begin
                res[k] = px[k];
            end else begin
                case (i_cfg.blend_select)
                    lutt_pkg::BLEND_REPLACE: res[k] = tone[k];
                    lutt_pkg::BLEND_ADD:     res[k] = psum[k][lutt_pkg::PIX_W] ? lutt_pkg::PIX_MAX
                                                      : psum[k][lutt_pkg::PIX_W-1:0];
                    lutt_pkg::BLEND_AVG:     res[k] = psum[k][lutt_pkg::PIX_W:1];
                    default:                 res[k] = px[k];
                endcase
            end
        end
        n_rsp.out_red   = res[0];
        n_rsp.out_green = res[1];
        n_rsp.out_blue  = res[2];
        n_rsp.out_last  = r_a_pix.in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_pix <= i_q_work.pix;
            for (int k = 0; k < lutt_pkg::NCH; k++) begin
                r_a_prod[k] <= lutt_pkg::PROD_W'(scale[k]) * lutt_pkg::PROD_W'(i_q_work.lum);
            end
        end
        if (b_ready && r_a_valid) begin
            r_b_rsp <= n_rsp;
        end
    end

    assign o_empty = !r_b_valid;
    assign o_rsp   = r_b_rsp;

endmodule
